[hdl/dbrf_pkg.sv]
package dbrf_pkg;

  // Default geometry of the block.
  localparam int CAPACITY_DEFAULT    = 256;
  localparam int QUEUE_COUNT_DEFAULT = 2;

  // Fixed field widths of the item and result ports.
  localparam int DATA_W   = 8;
  localparam int ACTION_W = 2;
  localparam int FILL_W   = 9;

  // Action codes carried by an input item. Code 3 has no meaning.
  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_CLEAR   = 2'd2
  } action_t;

endpackage

[hdl/dbrf_ram.sv]
module dbrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read of the old contents on a write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/dual_byte_ring_fifo.sv]
// Two independent byte FIFOs, each a ring of CAPACITY entries, sharing one
// single-port byte RAM. A transfer is taken at every rising edge where start
// is high and busy is low; busy is never raised, so one command can be given
// in every clock cycle. Each command (enqueue, dequeue or clear of the queue
// named by queue_select) yields exactly one result, shown for one cycle with
// done high in the cycle right after the command was taken: that is when the
// registered read port of the byte RAM returns a dequeued byte whose address
// was issued as the command was taken. The receiver cannot stall the block,
// so it must capture every result in the cycle done is high.
// A refused command (enqueue into a full queue, dequeue from an empty one, or
// the unused action code) leaves the queue unchanged and reports accepted low
// together with the current status of the queue.
module dual_byte_ring_fifo #(
  parameter int CAPACITY    = dbrf_pkg::CAPACITY_DEFAULT,
  parameter int QUEUE_COUNT = dbrf_pkg::QUEUE_COUNT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [dbrf_pkg::ACTION_W-1:0] action,
  input  logic                          queue_select,
  input  logic [dbrf_pkg::DATA_W-1:0]   data_in,
  output logic                          done,
  output logic                          accepted,
  output logic [dbrf_pkg::DATA_W-1:0]   data_out,
  output logic [dbrf_pkg::FILL_W-1:0]   fill_level,
  output logic                          is_empty,
  output logic                          is_full
);

  // Pointer, occupancy, queue index and RAM address widths.
  localparam int PW    = $clog2(CAPACITY);
  localparam int OW    = $clog2(CAPACITY + 1);
  localparam int QW    = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int DEPTH = QUEUE_COUNT * CAPACITY;
  localparam int AW    = $clog2(DEPTH);
  // A second queue exists only when the block is built with more than one.
  localparam logic HAS_Q1 = (QUEUE_COUNT > 1);

  // Per-queue control state: small register files indexed by queue_select.
  logic [PW-1:0] rd_ptr    [QUEUE_COUNT];
  logic [PW-1:0] wr_ptr    [QUEUE_COUNT];
  logic [OW-1:0] occupancy [QUEUE_COUNT];

  // Result registers, valid in the cycle where done is high.
  logic                        res_accepted;
  logic                        res_pop;
  logic [dbrf_pkg::FILL_W-1:0] res_fill;
  logic                        res_empty;
  logic                        res_full;

  // Command decode and the next state of the selected queue.
  logic                       take;
  logic                       q_ok;
  logic [QW-1:0]              qidx;
  logic [PW-1:0]              rp_cur;
  logic [PW-1:0]              wp_cur;
  logic [OW-1:0]              occ_cur;
  logic [PW-1:0]              rp_next;
  logic [PW-1:0]              wp_next;
  logic [OW-1:0]              occ_next;
  logic                       acc_next;
  logic                       pop_next;
  logic [AW-1:0]              base;
  logic                       ram_we;
  logic [AW-1:0]              ram_addr;
  logic [dbrf_pkg::DATA_W-1:0] ram_rdata;

  // Every command finishes its RAM access at the edge that takes it, and the
  // next command sees the updated pointers, so no command is ever held off.
  assign busy = 1'b0;
  assign take = start && !busy;
  assign q_ok = !queue_select || HAS_Q1;
  assign qidx = QW'(queue_select);

  assign rp_cur  = rd_ptr[qidx];
  assign wp_cur  = wr_ptr[qidx];
  assign occ_cur = occupancy[qidx];
  // Each queue owns a slice of CAPACITY bytes in the shared RAM.
  assign base    = AW'(qidx) * AW'(CAPACITY);

  always_comb begin
    rp_next  = rp_cur;
    wp_next  = wp_cur;
    occ_next = occ_cur;
    acc_next = 1'b0;
    pop_next = 1'b0;
    ram_we   = 1'b0;
    ram_addr = base + AW'(rp_cur);
    unique case (dbrf_pkg::action_t'(action))
      dbrf_pkg::ACT_ENQUEUE: begin
        if (occ_cur != OW'(CAPACITY)) begin
          ram_we   = take && q_ok;
          ram_addr = base + AW'(wp_cur);
          wp_next  = (wp_cur == PW'(CAPACITY - 1)) ? '0 : wp_cur + PW'(1);
          occ_next = occ_cur + OW'(1);
          acc_next = 1'b1;
        end
      end
      dbrf_pkg::ACT_DEQUEUE: begin
        // The read address is already the read pointer; the byte arrives
        // from the RAM's output register in the result cycle.
        if (occ_cur != '0) begin
          rp_next  = (rp_cur == PW'(CAPACITY - 1)) ? '0 : rp_cur + PW'(1);
          occ_next = occ_cur - OW'(1);
          acc_next = 1'b1;
          pop_next = 1'b1;
        end
      end
      dbrf_pkg::ACT_CLEAR: begin
        // Stored bytes stay in the RAM but can no longer be reached.
        rp_next  = '0;
        wp_next  = '0;
        occ_next = '0;
        acc_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  dbrf_ram #(
    .WIDTH(dbrf_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(data_in),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        rd_ptr[i]    <= '0;
        wr_ptr[i]    <= '0;
        occupancy[i] <= '0;
      end
    end else begin
      done <= take;
      if (take && q_ok) begin
        rd_ptr[qidx]    <= rp_next;
        wr_ptr[qidx]    <= wp_next;
        occupancy[qidx] <= occ_next;
      end
    end
  end

  // A command naming a queue that is not built reports all zeros.
  always_ff @(posedge clk) begin
    if (take) begin
      res_accepted <= q_ok && acc_next;
      res_pop      <= q_ok && pop_next;
      res_fill     <= q_ok ? dbrf_pkg::FILL_W'(occ_next) : '0;
      res_empty    <= q_ok && (occ_next == '0);
      res_full     <= q_ok && (occ_next == OW'(CAPACITY));
    end
  end

  assign accepted   = res_accepted;
  assign data_out   = res_pop ? ram_rdata : '0;
  assign fill_level = res_fill;
  assign is_empty   = res_empty;
  assign is_full    = res_full;

  // Every transfer taken yields exactly one result in the following cycle.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (done == $past(start)))
    else $error("result strobe does not follow the command by one cycle");

  // A queue can never be reported empty and full at once.
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> !(is_empty && is_full))
    else $error("queue reported both empty and full");

  // Only an accepted dequeue returns a nonzero byte.
  a_data_gated: assert property (@(posedge clk) disable iff (rst)
    (done && (data_out != '0)) |-> accepted)
    else $error("byte returned by a refused command");

  // An empty queue reports a fill level of zero.
  a_empty_level: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (fill_level == '0))
    else $error("empty queue with nonzero fill level");

endmodule

[tb/tb_dual_byte_ring_fifo.sv]
module tb_dual_byte_ring_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  import dbrf_pkg::*;

  localparam int CAP    = CAPACITY_DEFAULT;
  localparam int QUEUES = QUEUE_COUNT_DEFAULT;

  // The one action code that the block must treat as a no-op.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // Number of random commands to issue after the directed part.
  localparam int RANDOM_ITEMS = 200;

  // One result as the block reports it.
  typedef struct packed {
    logic              accepted;
    logic [DATA_W-1:0] data_out;
    logic [FILL_W-1:0] fill_level;
    logic              is_empty;
    logic              is_full;
  } fifo_status_t;

  // One row of the directed plan. A row can repeat its command; the byte then
  // counts up from the given value. Rows with a hand-written result use it in
  // place of the prediction, and those rows always have a repeat count of one.
  typedef struct {
    logic [ACTION_W-1:0] act;
    logic                q;
    logic [DATA_W-1:0]   d;
    int                  reps;
    bit                  fixed;
    fifo_status_t        want;
  } plan_row_t;

  localparam fifo_status_t ST_EMPTY_REFUSED = '{1'b0, 8'h00, 9'd0, 1'b1, 1'b0};
  localparam fifo_status_t ST_FULL_REFUSED  = '{1'b0, 8'h00, 9'd256, 1'b0, 1'b1};
  localparam fifo_status_t ST_CLEARED       = '{1'b1, 8'h00, 9'd0, 1'b1, 1'b0};
  localparam fifo_status_t ST_NONE          = '0;

  localparam int PLAN_ROWS = 24;

  // Directed plan: status after reset, the byte extremes, refusal on empty and
  // on full, the unused action code, pointer wrap in both directions, clear of
  // an empty, a partly filled and a full queue, and both queues interleaved.
  plan_row_t plan [PLAN_ROWS] = '{
    '{ACT_DEQUEUE, 1'b0, 8'h00, 1,   1'b1, ST_EMPTY_REFUSED},
    '{ACT_DEQUEUE, 1'b1, 8'hFF, 1,   1'b1, ST_EMPTY_REFUSED},
    '{ACT_UNUSED,  1'b0, 8'h5A, 1,   1'b1, ST_EMPTY_REFUSED},
    '{ACT_ENQUEUE, 1'b0, 8'h00, 1,   1'b1, '{1'b1, 8'h00, 9'd1, 1'b0, 1'b0}},
    '{ACT_ENQUEUE, 1'b0, 8'hFF, 1,   1'b1, '{1'b1, 8'h00, 9'd2, 1'b0, 1'b0}},
    '{ACT_DEQUEUE, 1'b0, 8'h00, 1,   1'b1, '{1'b1, 8'h00, 9'd1, 1'b0, 1'b0}},
    '{ACT_DEQUEUE, 1'b0, 8'h00, 1,   1'b1, '{1'b1, 8'hFF, 9'd0, 1'b1, 1'b0}},
    '{ACT_ENQUEUE, 1'b1, 8'hA5, CAP, 1'b0, ST_NONE},
    '{ACT_ENQUEUE, 1'b1, 8'h5A, 1,   1'b1, ST_FULL_REFUSED},
    '{ACT_UNUSED,  1'b1, 8'hC3, 1,   1'b1, ST_FULL_REFUSED},
    '{ACT_DEQUEUE, 1'b1, 8'h00, 1,   1'b0, ST_NONE},
    '{ACT_ENQUEUE, 1'b1, 8'h3C, 1,   1'b0, ST_NONE},
    '{ACT_DEQUEUE, 1'b1, 8'h00, 255, 1'b0, ST_NONE},
    '{ACT_DEQUEUE, 1'b1, 8'h00, 1,   1'b0, ST_NONE},
    '{ACT_DEQUEUE, 1'b1, 8'h00, 1,   1'b1, ST_EMPTY_REFUSED},
    '{ACT_ENQUEUE, 1'b0, 8'h12, 10,  1'b0, ST_NONE},
    '{ACT_CLEAR,   1'b0, 8'h00, 1,   1'b1, ST_CLEARED},
    '{ACT_DEQUEUE, 1'b0, 8'h00, 1,   1'b1, ST_EMPTY_REFUSED},
    '{ACT_CLEAR,   1'b1, 8'h00, 1,   1'b1, ST_CLEARED},
    '{ACT_ENQUEUE, 1'b1, 8'h80, CAP, 1'b0, ST_NONE},
    '{ACT_CLEAR,   1'b1, 8'h00, 1,   1'b1, ST_CLEARED},
    '{ACT_ENQUEUE, 1'b0, 8'h55, 1,   1'b0, ST_NONE},
    '{ACT_ENQUEUE, 1'b1, 8'hAA, 1,   1'b0, ST_NONE},
    '{ACT_DEQUEUE, 1'b0, 8'h00, 1,   1'b0, ST_NONE}
  };

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [ACTION_W-1:0] action;
  logic                queue_select;
  logic [DATA_W-1:0]   data_in;
  logic                done;
  logic                accepted;
  logic [DATA_W-1:0]   data_out;
  logic [FILL_W-1:0]   fill_level;
  logic                is_empty;
  logic                is_full;

  // Sideband that travels with each command: a hand-written result to expect
  // instead of the predicted one.
  bit           use_fixed;
  fifo_status_t fixed_status;

  // Private copy of both queues, kept in step with every accepted transfer.
  logic [DATA_W-1:0] model_bytes [QUEUES][CAP];
  int                model_rd    [QUEUES];
  int                model_wr    [QUEUES];
  int                model_count [QUEUES];

  // Results owed by the block, oldest first.
  fifo_status_t pending_results [$];
  int           fault_count;

  dual_byte_ring_fifo #(
    .CAPACITY    (CAP),
    .QUEUE_COUNT (QUEUES)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .queue_select (queue_select),
    .data_in      (data_in),
    .done         (done),
    .accepted     (accepted),
    .data_out     (data_out),
    .fill_level   (fill_level),
    .is_empty     (is_empty),
    .is_full      (is_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one command to the private queues and return what the block must
  // report. Refused and unused commands leave the queues as they are, but the
  // status of the selected queue is still reported.
  function automatic fifo_status_t fifo_model_apply(logic [ACTION_W-1:0] act, logic q,
                                                    logic [DATA_W-1:0] d);
    fifo_status_t r;
    int           qi;
    qi = int'(q);
    r  = '0;
    if (act == ACT_ENQUEUE) begin
      if (model_count[qi] < CAP) begin
        model_bytes[qi][model_wr[qi]] = d;
        model_wr[qi] = (model_wr[qi] + 1) % CAP;
        model_count[qi]++;
        r.accepted = 1'b1;
      end
    end else if (act == ACT_DEQUEUE) begin
      if (model_count[qi] != 0) begin
        r.data_out = model_bytes[qi][model_rd[qi]];
        model_rd[qi] = (model_rd[qi] + 1) % CAP;
        model_count[qi]--;
        r.accepted = 1'b1;
      end
    end else if (act == ACT_CLEAR) begin
      model_rd[qi]    = 0;
      model_wr[qi]    = 0;
      model_count[qi] = 0;
      r.accepted      = 1'b1;
    end
    r.fill_level = FILL_W'(model_count[qi]);
    r.is_empty   = (model_count[qi] == 0);
    r.is_full    = (model_count[qi] == CAP);
    return r;
  endfunction

  function automatic string status_text(fifo_status_t s);
    return $sformatf("accepted=%0b data_out=0x%02h fill_level=%0d is_empty=%0b is_full=%0b",
                     s.accepted, s.data_out, s.fill_level, s.is_empty, s.is_full);
  endfunction

  task automatic note_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Scoreboard. A command accepted at this edge is predicted before any result
  // of this edge is checked, so the check holds whatever the block's latency.
  always @(posedge clk) begin
    fifo_status_t predicted;
    fifo_status_t got;
    fifo_status_t want;
    if (!rst) begin
      if (start && !busy) begin
        predicted = fifo_model_apply(action, queue_select, data_in);
        pending_results.push_back(use_fixed ? fixed_status : predicted);
      end
      if (done) begin
        got = '{accepted, data_out, fill_level, is_empty, is_full};
        if (pending_results.size() == 0) begin
          note_fault($sformatf("result with nothing pending: %s", status_text(got)));
        end else begin
          want = pending_results.pop_front();
          if (got.accepted !== want.accepted || got.data_out !== want.data_out ||
              got.fill_level !== want.fill_level || got.is_empty !== want.is_empty ||
              got.is_full !== want.is_full) begin
            note_fault($sformatf("mismatch\n  expected %s\n  actual   %s",
                                 status_text(want), status_text(got)));
          end
        end
      end
    end
  end

  // Present one command after a gap of idle cycles and hold it until the
  // transfer happens. Start stays high between back-to-back commands.
  task automatic issue_command(logic [ACTION_W-1:0] act, logic q, logic [DATA_W-1:0] d,
                               int gap, bit fixed, fifo_status_t want);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    action       <= act;
    queue_select <= q;
    data_in      <= d;
    use_fixed    <= fixed;
    fixed_status <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random traffic in bursts. Each burst leans toward filling or draining, or
  // stays balanced, and mostly works one queue, so that fill levels rise and
  // fall. Some bursts run without idle cycles.
  task automatic run_random_traffic();
    int                  left;
    int                  burst;
    int                  enq_pct;
    int                  pick;
    int                  gap;
    bit                  hot_q;
    bit                  no_idle;
    logic [ACTION_W-1:0] act;
    logic                q;
    left = RANDOM_ITEMS;
    while (left > 0) begin
      burst = $urandom_range(20, 400);
      case ($urandom_range(0, 2))
        0: enq_pct = 90;
        1: enq_pct = 10;
        default: enq_pct = 50;
      endcase
      hot_q   = 1'($urandom_range(0, 1));
      no_idle = ($urandom_range(0, 3) == 0);
      while (burst > 0 && left > 0) begin
        pick = $urandom_range(0, 199);
        if (pick == 0)
          act = ACT_CLEAR;
        else if (pick < 4)
          act = ACT_UNUSED;
        else if ($urandom_range(0, 99) < enq_pct)
          act = ACT_ENQUEUE;
        else
          act = ACT_DEQUEUE;
        q   = ($urandom_range(0, 99) < 85) ? hot_q : ~hot_q;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        issue_command(act, q, DATA_W'($urandom_range(0, 255)), gap, 1'b0, ST_NONE);
        // Every command, the unused code included, yields one result.
        left--;
        burst--;
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    action       <= ACT_ENQUEUE;
    queue_select <= 1'b0;
    data_in      <= '0;
    use_fixed    <= 1'b0;
    fixed_status <= '0;
    fault_count  = 0;
    for (int qi = 0; qi < QUEUES; qi++) begin
      model_rd[qi]    = 0;
      model_wr[qi]    = 0;
      model_count[qi] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        issue_command(plan[i].act, plan[i].q, plan[i].d + k[DATA_W-1:0],
                      $urandom_range(0, 14), plan[i].fixed, plan[i].want);
      end
    end

    run_random_traffic();

    @(negedge clk);
    start <= 1'b0;

    // Drain: every owed result must arrive, then the bench waits on to catch any
    // stray strobe.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run of about a thousand commands
  // with the longest idle gaps.
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
